[hdl/mwdw_pkg.sv]
// ----------------------------------------------------------------------------
// Multiword divide-by-word package
// Shared widths, defaults and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mwdw_pkg;

    // Width of the divisor, of the kept remainder and of the word ports.
    localparam int REG_BITS = 64;

    // Default width of one dividend word that takes part in the division.
    localparam int WORD_BITS_DEF = 64;

    // Step counter width; it covers the longest phase of REG_BITS steps.
    localparam int CNT_BITS = $clog2(REG_BITS);

    // Reset value of the divisor register.
    localparam logic [REG_BITS-1:0] DIVISOR_RST = REG_BITS'(1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // capture the word and set up the first phase
        logic step;       // one restoring radix-2 step
        logic load_word;  // move the captured word into the bit source
        logic finish;     // load the output register and update the kept remainder
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rem_below;  // kept remainder is below the divisor
        logic div_zero;   // divisor register holds zero
    } t_dp_status;

endpackage

[hdl/mwdw_datapath.sv]
// ----------------------------------------------------------------------------
// Multiword divide-by-word datapath
// Divisor and kept-remainder registers, the radix-2 restoring divider step
// and the output register.
// ----------------------------------------------------------------------------
module mwdw_datapath #(
    parameter int WORD_BITS = mwdw_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mwdw_pkg::REG_BITS-1:0] i_cfg_divisor,
    input  logic [mwdw_pkg::REG_BITS-1:0] i_dividend_word,
    input  logic                          i_last_word,
    input  mwdw_pkg::t_dp_cmd             i_cmd,
    output mwdw_pkg::t_dp_status          o_status,
    output logic [mwdw_pkg::REG_BITS-1:0] o_quotient_word,
    output logic [mwdw_pkg::REG_BITS-1:0] o_remainder_value,
    output logic                          o_end_of_number
);

    localparam int RegBits = mwdw_pkg::REG_BITS;
    localparam int Pad     = RegBits - WORD_BITS;

    logic [RegBits-1:0]   r_divisor;
    logic [RegBits-1:0]   r_part_rem;
    logic [RegBits-1:0]   r_rem;
    logic [RegBits-1:0]   r_src;
    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] r_quot;
    logic                 r_last;
    logic [WORD_BITS-1:0] r_out_quot;
    logic [RegBits-1:0]   r_out_rem;
    logic                 r_out_last;

    logic [RegBits:0]     trial;
    logic [RegBits+1:0]   diff;
    logic                 q_bit;
    logic [RegBits-1:0]   step_rem;
    logic [RegBits-1:0]   word_aligned;

    // Shift the next source bit into the remainder and subtract the divisor
    // when the shifted value reaches it. The remainder stays below the
    // divisor, so the difference always fits the register.
    always_comb begin
        trial        = {r_rem, r_src[RegBits-1]};
        diff         = {1'b0, trial} - {2'b00, r_divisor};
        q_bit        = ~diff[RegBits+1];
        step_rem     = q_bit ? diff[RegBits-1:0] : trial[RegBits-1:0];
        word_aligned = RegBits'(r_word) << Pad;
    end

    assign o_status.rem_below = (r_part_rem < r_divisor);
    assign o_status.div_zero  = (r_divisor == '0);

    // Control-relevant state: the divisor and the kept remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor  <= mwdw_pkg::DIVISOR_RST;
            r_part_rem <= '0;
        end else begin
            if (i_cfg_we) begin
                r_divisor <= i_cfg_divisor;
            end
            if (i_cmd.finish) begin
                r_part_rem <= r_last ? '0 : r_rem;
            end
        end
    end

    // Working and output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_word <= i_dividend_word[WORD_BITS-1:0];
            r_last <= i_last_word;
            if (o_status.div_zero) begin
                r_quot <= '1;
                r_rem  <= '0;
            end else if (o_status.rem_below) begin
                r_rem <= r_part_rem;
                r_src <= RegBits'(i_dividend_word[WORD_BITS-1:0]) << Pad;
            end else begin
                r_rem <= '0;
                r_src <= r_part_rem;
            end
        end else begin
            if (i_cmd.step) begin
                r_rem  <= step_rem;
                r_quot <= {r_quot[WORD_BITS-2:0], q_bit};
            end
            if (i_cmd.load_word) begin
                r_src <= word_aligned;
            end else if (i_cmd.step) begin
                r_src <= r_src << 1;
            end
        end
        if (i_cmd.finish) begin
            r_out_quot <= r_quot;
            r_out_rem  <= r_rem;
            r_out_last <= r_last;
        end
    end

    assign o_quotient_word   = RegBits'(r_out_quot);
    assign o_remainder_value = r_out_rem;
    assign o_end_of_number   = r_out_last;

endmodule

[hdl/mwdw_ctrl.sv]
// ----------------------------------------------------------------------------
// Multiword divide-by-word controller
// Sequences the reduce and divide phases and owns both handshakes.
// ----------------------------------------------------------------------------
module mwdw_ctrl #(
    parameter int WORD_BITS = mwdw_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  mwdw_pkg::t_dp_status i_status,
    output mwdw_pkg::t_dp_cmd    o_cmd
);

    localparam int CntBits = mwdw_pkg::CNT_BITS;
    localparam logic [CntBits-1:0] ReduceLast = CntBits'(mwdw_pkg::REG_BITS - 1);
    localparam logic [CntBits-1:0] DivideLast = CntBits'(WORD_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_DIVIDE,
        S_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic [CntBits-1:0] r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_status.div_zero) begin
                        n_state = S_FINISH;
                    end else if (i_status.rem_below) begin
                        n_state = S_DIVIDE;
                        n_cnt   = DivideLast;
                    end else begin
                        n_state = S_REDUCE;
                        n_cnt   = ReduceLast;
                    end
                end
            end
            S_REDUCE: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    o_cmd.load_word = 1'b1;
                    n_cnt           = DivideLast;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hdl/multiword_divide_by_word.sv]
// ----------------------------------------------------------------------------
// Multiword divide-by-word
// Short division of a multiword unsigned number by a 64-bit divisor register.
// ----------------------------------------------------------------------------
// Dividend words enter most significant first, one transaction per word, and
// each produces one result transaction carrying the quotient word at the same
// position, the running remainder and an end-of-number flag copied from the
// input. The remainder is kept between words and returns to zero after the
// word marked last, so the remainder on that result is the remainder of the
// whole number. The divisor is written through the configuration channel,
// which is always ready; it resets to one and should be written only while
// no word is in flight. Words are processed one at a time by a single
// restoring radix-2 step that retires one quotient bit per cycle. If the
// divisor was changed in the middle of a number and the kept remainder is
// no longer below it, the remainder is first reduced with 64 further steps.
// A zero divisor yields an all-ones quotient word and a zero remainder.
// The result sits in an output register, so a new word is accepted while the
// previous result still waits to be taken.
// ----------------------------------------------------------------------------
module multiword_divide_by_word #(
    parameter int WORD_BITS = mwdw_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel: the divisor.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mwdw_pkg::REG_BITS-1:0] i_cfg_divisor,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mwdw_pkg::REG_BITS-1:0] i_dividend_word,
    input  logic                          i_last_word,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mwdw_pkg::REG_BITS-1:0] o_quotient_word,
    output logic [mwdw_pkg::REG_BITS-1:0] o_remainder_value,
    output logic                          o_end_of_number
);

    mwdw_pkg::t_dp_cmd    cmd;
    mwdw_pkg::t_dp_status status;

    // The divisor register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller decides which phase runs and when the output register
    // may be loaded; the datapath holds every payload register.
    mwdw_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mwdw_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_divisor     (i_cfg_divisor),
        .i_dividend_word   (i_dividend_word),
        .i_last_word       (i_last_word),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_quotient_word   (o_quotient_word),
        .o_remainder_value (o_remainder_value),
        .o_end_of_number   (o_end_of_number)
    );

endmodule

[tb/tb_multiword_divide_by_word.sv]
// ----------------------------------------------------------------------------
// Testbench for the multiword divide-by-word block
// Streams multiword dividends through the block under a series of divisor
// settings and checks every quotient word, remainder and end flag against a
// cycle-free prediction built from 128-by-64 integer division.
// ----------------------------------------------------------------------------
module tb_multiword_divide_by_word;

    localparam int REG_BITS = mwdw_pkg::REG_BITS;

    // Items on the two data channels.
    typedef struct {
        logic [REG_BITS-1:0] word;
        logic                last;
    } t_word_item;

    typedef struct {
        logic [REG_BITS-1:0] quotient;
        logic [REG_BITS-1:0] remainder;
        logic                eon;
    } t_division_result;

    localparam logic [REG_BITS-1:0] ALL_ONES = '1;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_WORDS   = 78;
    localparam int MAX_REPORTS   = 50;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_valid     = 1'b0;
    logic [REG_BITS-1:0] i_cfg_divisor   = '0;
    logic                i_in_valid      = 1'b0;
    logic [REG_BITS-1:0] i_dividend_word = '0;
    logic                i_last_word     = 1'b0;
    logic                i_out_stall     = 1'b0;

    logic                o_cfg_ready;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [REG_BITS-1:0] o_quotient_word;
    logic [REG_BITS-1:0] o_remainder_value;
    logic                o_end_of_number;

    // Words waiting to be offered, and the results predicted for words that
    // the block has already taken, oldest first.
    t_word_item       pending_words[$];
    t_division_result expected_results[$];

    // Our own copy of the block's register and of the remainder it carries.
    logic [REG_BITS-1:0] divisor_model;
    logic [REG_BITS-1:0] kept_remainder;

    // Random idling on both channels is switched off for a stretch of the run;
    // hold_off is the long receiver stall that fills the block up.
    logic idle_en  = 1'b1;
    logic hold_off = 1'b0;

    int mismatches      = 0;
    int words_accepted  = 0;
    int results_checked = 0;
    int numbers_done    = 0;
    int divisor_writes  = 0;

    multiword_divide_by_word u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_divisor     (i_cfg_divisor),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_dividend_word   (i_dividend_word),
        .i_last_word       (i_last_word),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_quotient_word   (o_quotient_word),
        .o_remainder_value (o_remainder_value),
        .o_end_of_number   (o_end_of_number)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // One word of short division: the kept remainder and the new word form a
    // 128-bit value which is divided by the current divisor. If the divisor
    // was lowered part way through a number the kept remainder may exceed it,
    // in which case the quotient word is just the low half of the true
    // quotient. A zero divisor gives an all-ones quotient and no remainder.
    function automatic t_division_result divide_next_word(
        input logic [REG_BITS-1:0] word,
        input logic                last
    );
        t_division_result      res;
        logic [2*REG_BITS-1:0] numer;
        logic [2*REG_BITS-1:0] denom;
        numer = {kept_remainder, word};
        denom = {{REG_BITS{1'b0}}, divisor_model};
        if (divisor_model == '0) begin
            res.quotient  = ALL_ONES;
            res.remainder = '0;
        end else begin
            res.quotient  = REG_BITS'(numer / denom);
            res.remainder = REG_BITS'(numer % denom);
        end
        res.eon        = last;
        kept_remainder = last ? '0 : res.remainder;
        return res;
    endfunction

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(
        input string               what,
        input logic [REG_BITS-1:0] got,
        input logic [REG_BITS-1:0] want
    );
        if (mismatches < MAX_REPORTS) begin
            $display("MISMATCH %s on result %0d: got %h, expected %h",
                     what, results_checked, got, want);
        end
        mismatches++;
    endtask

    // Input driver. A new word is put on the bus whenever the current one has
    // been taken or nothing is offered; a stalled transaction stays put. The
    // prediction is made at the edge where the block accepts the word, so
    // the kept remainder follows the order in which the block sees them.
    always @(posedge i_clk) begin
        t_word_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(divide_next_word(i_dividend_word, i_last_word));
                words_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 && !(idle_en && $urandom_range(99) < 6)) begin
                    nxt = pending_words.pop_front();
                    i_in_valid      <= 1'b1;
                    i_dividend_word <= nxt.word;
                    i_last_word     <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Every result transaction is compared field by field with
    // the oldest prediction; the stall for the next cycle is chosen here.
    always @(posedge i_clk) begin
        t_division_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_quotient_word, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_quotient_word !== want.quotient) begin
                        report_mismatch("quotient_word", o_quotient_word, want.quotient);
                    end
                    if (o_remainder_value !== want.remainder) begin
                        report_mismatch("remainder_value", o_remainder_value, want.remainder);
                    end
                    if (o_end_of_number !== want.eon) begin
                        report_mismatch("end_of_number", REG_BITS'(o_end_of_number),
                                        REG_BITS'(want.eon));
                    end
                    if (want.eon) begin
                        numbers_done++;
                    end
                end
                results_checked++;
            end
            i_out_stall <= hold_off || (idle_en && $urandom_range(99) < 6);
        end
    end

    // Once traffic is well under way the receiver refuses results for a long
    // stretch, while the sender keeps offering words, so that the output
    // register fills and the block has to stall its input.
    initial begin
        wait (results_checked >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Generous limit: the slowest legal run is well under a fifth of this.
    initial begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic add_word(input logic [REG_BITS-1:0] word, input logic last);
        t_word_item it;
        it.word = word;
        it.last = last;
        pending_words.push_back(it);
    endtask

    // Waits, on falling edges, until every queued word has been taken and
    // every predicted result has come back. Each word gives exactly one
    // result, so the block is idle at that point.
    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || i_in_valid || expected_results.size() != 0);
    endtask

    // Writes the divisor through the configuration channel, waiting for ready,
    // and returns on a falling edge so that new words are queued away from
    // the driver's edge.
    task automatic set_divisor(input logic [REG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_divisor <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        divisor_model  = value;
        divisor_writes++;
        @(negedge i_clk);
    endtask

    function automatic logic [REG_BITS-1:0] random_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return REG_BITS'($urandom_range(255));
            3:       return ALL_ONES - REG_BITS'($urandom_range(255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A spread of divisors: one, the largest, small ones, 32-bit ones, powers
    // of two and values with the top bit set, besides plain random ones.
    function automatic logic [REG_BITS-1:0] pick_divisor(input int phase);
        logic [REG_BITS-1:0] d;
        case (phase % 8)
            0:       d = REG_BITS'(1);
            1:       d = ALL_ONES;
            2:       d = REG_BITS'($urandom_range(16, 2));
            3:       d = REG_BITS'($urandom);
            4:       d = REG_BITS'(1) << $urandom_range(63);
            5:       d = {$urandom, $urandom} | (REG_BITS'(1) << (REG_BITS - 1));
            default: d = {$urandom, $urandom};
        endcase
        return (d == '0) ? REG_BITS'(1) : d;
    endfunction

    initial begin
        int len;
        int count;
        divisor_model  = mwdw_pkg::DIVISOR_RST;
        kept_remainder = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. First the divisor left by reset, which is one: the
        // quotient is the word itself and the remainder stays zero.
        add_word(ALL_ONES, 1'b1);
        add_word('0, 1'b1);
        settle();

        // Largest divisor, including a remainder one short of it.
        set_divisor(ALL_ONES);
        add_word(ALL_ONES, 1'b0);
        add_word(ALL_ONES, 1'b1);
        add_word(ALL_ONES - 1, 1'b0);
        add_word(ALL_ONES, 1'b1);
        settle();

        set_divisor(REG_BITS'(7));
        add_word(ALL_ONES, 1'b0);
        add_word(64'h0123_4567_89ab_cdef, 1'b0);
        add_word(ALL_ONES, 1'b1);
        settle();

        // A divisor that fits in 32 bits.
        set_divisor(REG_BITS'(32'hffff_ffff));
        add_word(64'hdead_beef_cafe_f00d, 1'b0);
        add_word('0, 1'b0);
        add_word(ALL_ONES, 1'b1);
        settle();

        set_divisor(REG_BITS'(1) << 63);
        add_word(ALL_ONES, 1'b0);
        add_word(REG_BITS'(1), 1'b1);
        settle();

        // Divisor lowered part way through a number: the kept remainder is
        // then far above the new divisor and the quotient word wraps.
        set_divisor(ALL_ONES);
        add_word(ALL_ONES - 1, 1'b0);
        settle();
        set_divisor(REG_BITS'(3));
        add_word(64'h5555_5555_5555_5555, 1'b1);
        settle();
        set_divisor(ALL_ONES);
        add_word(ALL_ONES - 1, 1'b0);
        settle();
        set_divisor(REG_BITS'(1));
        add_word(ALL_ONES, 1'b1);
        settle();

        // Random part: numbers of random length and content under a new
        // divisor each phase. Now and then a phase ends inside a number, so
        // the next divisor meets a carried remainder. Idling is off for a
        // stretch of phases in the middle.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_divisor(pick_divisor(ph));
            idle_en = !(ph >= 8 && ph < 12);
            count = 0;
            while (count < PHASE_WORDS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(5, 1);
                for (int i = 0; i < len; i++) begin
                    add_word(random_word(), i == len - 1);
                end
                count += len;
            end
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(3, 1)) add_word(random_word(), 1'b0);
            end
            settle();
        end

        // Let anything stray show up at the output before judging.
        repeat (150) @(posedge i_clk);

        $display("Covered %0d dividend words in %0d complete numbers over %0d divisor settings,",
                 words_accepted, numbers_done, divisor_writes);
        $display("including divisor changes inside a number and a long output hold-off.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/mwdw_pkg.sv
hdl/mwdw_datapath.sv
hdl/mwdw_ctrl.sv
hdl/multiword_divide_by_word.sv
tb/tb_multiword_divide_by_word.sv
